// ===== hw/rtl/dcbw_pkg.sv =====
// Package for the byte/word DMA copy engine: register indexes, control bits
// and the copy command struct shared by the sequencer and the top level.
// No dependencies.
package dcbw_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned IdxW   = 3;

  // Input request tdata: {write_data, reg_index}, padded to whole bytes
  localparam int unsigned InDataW  = ((IdxW + HalfW + 7) / 8) * 8;
  // Output command tdata: {dst_addr, src_addr}
  localparam int unsigned OutDataW = 2 * AddrW;

  // Control register bits
  localparam logic [HalfW-1:0] CtrlStartMask = 16'h8800;
  localparam logic [HalfW-1:0] CtrlWordBit   = 16'h1000;

  // Request kind carried in tuser
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeTick  = 1'b1;

  typedef enum logic [IdxW-1:0] {
    RegSrcHi = 3'd0,
    RegSrcLo = 3'd1,
    RegDstHi = 3'd2,
    RegDstLo = 3'd3,
    RegCount = 3'd4,
    RegCtrl  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic             word_size;
    logic             last;
  } dcbw_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             final_xfer;
    logic             word_mode;
    logic [AddrW-1:0] src_addr;
  } dcbw_status_t;

endpackage

// ===== hw/rtl/dcbw_seq.sv =====
// Register file and transfer sequencer of the DMA copy engine.
// Takes one accepted request per cycle; depends on dcbw_pkg.
module dcbw_seq
  import dcbw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               mode_i,
  input  logic [IdxW-1:0]    reg_index_i,
  input  logic [HalfW-1:0]   write_data_i,
  output logic               cmd_valid_o,
  output dcbw_cmd_t          cmd_o,
  output dcbw_status_t       status_o
);

  logic [AddrW-1:0]  src_q, src_d;
  logic [AddrW-1:0]  dst_q, dst_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic              busy_q, busy_d;
  logic              word_q, word_d;

  logic              wr_en;
  logic              tick;
  logic [AddrW-1:0]  stride;

  assign wr_en  = req_valid_i && (mode_i == ModeWrite) && !busy_q;
  assign tick   = req_valid_i && (mode_i == ModeTick) && busy_q;
  assign stride = {{(AddrW-2){1'b0}}, word_q, !word_q};

  always_comb begin
    src_d    = src_q;
    dst_d    = dst_q;
    count_d  = count_q;
    remain_d = remain_q;
    busy_d   = busy_q;
    word_d   = word_q;
    if (wr_en) begin
      unique case (reg_idx_e'(reg_index_i))
        RegSrcHi: src_d   = {write_data_i, src_q[HalfW-1:0]};
        RegSrcLo: src_d   = {src_q[AddrW-1:HalfW], write_data_i};
        RegDstHi: dst_d   = {write_data_i, dst_q[HalfW-1:0]};
        RegDstLo: dst_d   = {dst_q[AddrW-1:HalfW], write_data_i};
        RegCount: count_d = write_data_i;
        RegCtrl: begin
          if ((write_data_i & CtrlStartMask) != '0) begin
            busy_d   = 1'b1;
            remain_d = count_q;
            word_d   = (write_data_i & CtrlWordBit) != '0;
          end
        end
        default: ;  // unused index, write dropped
      endcase
    end else if (tick) begin
      src_d = src_q + stride;
      dst_d = dst_q + stride;
      if (remain_q == '0) begin
        busy_d = 1'b0;
      end else begin
        remain_d = remain_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q    <= '0;
      dst_q    <= '0;
      count_q  <= '0;
      remain_q <= '0;
      busy_q   <= 1'b0;
      word_q   <= 1'b0;
    end else begin
      src_q    <= src_d;
      dst_q    <= dst_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      busy_q   <= busy_d;
      word_q   <= word_d;
    end
  end

  assign cmd_valid_o         = tick;
  assign cmd_o.src_addr      = src_q;
  assign cmd_o.dst_addr      = dst_q;
  assign cmd_o.word_size     = word_q;
  assign cmd_o.last          = (remain_q == '0);

  assign status_o.busy       = busy_q;
  assign status_o.final_xfer = (remain_q == '0);
  assign status_o.word_mode  = word_q;
  assign status_o.src_addr   = src_q;

endmodule

// ===== hw/rtl/dma_copy_engine_byte_word.sv =====
// Top level of the byte/word DMA copy engine: request stream in, copy
// command stream out. Uses dcbw_pkg and dcbw_seq.
//
// Software programs the engine over the request stream: tuser low selects a
// register write (source high/low, destination high/low, count, control);
// tuser high is one tick of transfer progress. A control write with bit 15
// or bit 11 set starts a run of count+1 copy commands, in word mode when
// bit 12 is set. Each tick while busy produces one command holding source,
// destination, word size (tuser) and a last mark (tlast); both addresses
// then step by 2 or 1 and wrap at 32 bits. Register writes during a run,
// control writes without a start bit, unused indexes and ticks while idle
// produce nothing. One request is taken every cycle: the sequencer computes its
// whole update combinationally, and its command goes into an output register
// backed by a one-entry skid buffer, so s_axis_tready drops only while both
// are full. While the output stalls, a command waits in the skid buffer first.
module dma_copy_engine_byte_word
  import dcbw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [2:0] reg_index, [18:3] write_data
  input  logic                s_axis_tuser,   // [0] mode
  // copy command stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [31:0] src_addr, [63:32] dst_addr
  output logic                m_axis_tuser,   // [0] word_size
  output logic                m_axis_tlast    // last
);

  logic         req_acc;
  logic         cmd_valid;
  dcbw_cmd_t    cmd;
  dcbw_status_t status;

  logic         out_valid_q, out_valid_d;
  dcbw_cmd_t    out_q, out_d;
  logic         skid_valid_q, skid_valid_d;
  dcbw_cmd_t    skid_q, skid_d;
  logic         out_load;
  logic         produce;

  // Ready as long as the skid slot is free
  assign s_axis_tready = !skid_valid_q;
  assign req_acc       = s_axis_tvalid && s_axis_tready;

  dcbw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_acc),
    .mode_i       (s_axis_tuser),
    .reg_index_i  (s_axis_tdata[IdxW-1:0]),
    .write_data_i (s_axis_tdata[IdxW+HalfW-1:IdxW]),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .status_o     (status)
  );

  assign produce  = cmd_valid;
  assign out_load = !out_valid_q || m_axis_tready;

  // Output register refills from skid first, to keep command order
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_load) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = cmd;
        out_valid_d = produce;
      end
    end else if (produce) begin
      skid_d       = cmd;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.dst_addr, out_q.src_addr};
  assign m_axis_tuser  = out_q.word_size;
  assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
  // final tick of a run must drop busy
  a_run_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && s_axis_tuser == ModeTick && status.busy && status.final_xfer)
    |=> !status.busy)
    else $error("engine still busy after last transfer");

  // source address steps by the transfer width on every command
  a_src_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && s_axis_tuser == ModeTick && status.busy)
    |=> status.src_addr == $past(status.src_addr)
        + (($past(status.word_mode)) ? 32'd2 : 32'd1))
    else $error("source address did not advance by the stride");

  // skid slot only fills while the output register is stalled
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid buffer filled without an output stall");
`endif

endmodule

// ===== tb/sv/dcbw_cmd_checker.sv =====
// Checker for the byte/word DMA copy engine: watches the request and command
// streams, predicts each copy command and compares it field by field.
// Depends on dcbw_pkg for widths, register indexes and control bits.
module dcbw_cmd_checker
  import dcbw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tuser_i,
  input  logic                m_tlast_i,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the engine's registers
  logic [AddrW-1:0]  src_q;
  logic [AddrW-1:0]  dst_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] left_q;
  logic              busy_q;
  logic              word_q;

  dcbw_cmd_t   pending_cmds[$];
  int unsigned err_count = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t dcbw_cmd_checker: %s", $realtime, msg);
  endtask

  // apply one request to the shadow state; a tick while busy yields a command
  task automatic step_engine(input logic mode, input logic [IdxW-1:0] idx,
                             input logic [HalfW-1:0] data);
    dcbw_cmd_t cmd;
    if (mode == ModeWrite) begin
      if (!busy_q) begin
        case (reg_idx_e'(idx))
          RegSrcHi: src_q[AddrW-1:HalfW] = data;
          RegSrcLo: src_q[HalfW-1:0]     = data;
          RegDstHi: dst_q[AddrW-1:HalfW] = data;
          RegDstLo: dst_q[HalfW-1:0]     = data;
          RegCount: count_q              = data;
          RegCtrl: begin
            if ((data & CtrlStartMask) != '0) begin
              busy_q = 1'b1;
              left_q = count_q;
              word_q = (data & CtrlWordBit) != '0;
            end
          end
          default: ;
        endcase
      end
    end else if (busy_q) begin
      cmd.src_addr  = src_q;
      cmd.dst_addr  = dst_q;
      cmd.word_size = word_q;
      cmd.last      = (left_q == '0);
      pending_cmds.push_back(cmd);
      src_q = src_q + (word_q ? 32'd2 : 32'd1);
      dst_q = dst_q + (word_q ? 32'd2 : 32'd1);
      if (left_q == '0) busy_q = 1'b0;
      else left_q = left_q - 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dcbw_cmd_t want;
    if (!rst_ni) begin
      src_q   = '0;
      dst_q   = '0;
      count_q = '0;
      left_q  = '0;
      busy_q  = 1'b0;
      word_q  = 1'b0;
      pending_cmds.delete();
    end else begin
      // a command leaving now belongs to an earlier request, so check first
      if (m_tvalid_i && m_tready_i) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected command src %h dst %h",
                                    m_tdata_i[AddrW-1:0], m_tdata_i[2*AddrW-1:AddrW]));
        end else begin
          want = pending_cmds.pop_front();
          if (m_tdata_i[AddrW-1:0] !== want.src_addr)
            report_mismatch($sformatf("src_addr expected %h got %h",
                                      want.src_addr, m_tdata_i[AddrW-1:0]));
          if (m_tdata_i[2*AddrW-1:AddrW] !== want.dst_addr)
            report_mismatch($sformatf("dst_addr expected %h got %h",
                                      want.dst_addr, m_tdata_i[2*AddrW-1:AddrW]));
          if (m_tuser_i !== want.word_size)
            report_mismatch($sformatf("word_size expected %b got %b",
                                      want.word_size, m_tuser_i));
          if (m_tlast_i !== want.last)
            report_mismatch($sformatf("last expected %b got %b", want.last, m_tlast_i));
        end
      end
      if (s_tvalid_i && s_tready_i)
        step_engine(s_tuser_i, s_tdata_i[IdxW-1:0], s_tdata_i[IdxW+HalfW-1:IdxW]);
    end
    err_count_o <= err_count;
    pending_o   <= pending_cmds.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the byte/word DMA copy engine: clock, reset, request
// stimulus, command-side back-pressure and the verdict.
// Depends on dcbw_pkg, dma_copy_engine_byte_word and dcbw_cmd_checker.
module tb_top;
  import dcbw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalReqs  = 1050;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TailCycles = 20;

  // indexes the engine has no register behind
  localparam logic [IdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [IdxW-1:0] RegSpare7 = 3'd7;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = ModeWrite;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned err_count;
  int unsigned cmds_pending;
  int unsigned req_sent = 0;
  int unsigned cycles   = 0;
  bit          tx_calm  = 1'b0;   // sender runs back to back while set

  always #4 clk_i = ~clk_i;

  dma_copy_engine_byte_word u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dcbw_cmd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .err_count_o (err_count),
    .pending_o   (cmds_pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Command side back-pressure: windows of steady readiness alternate with
  // windows of random stalls, mostly short and now and then long.
  int unsigned rx_hold   = 0;
  int unsigned rx_window = 0;
  bit          rx_calm   = 1'b0;

  always @(posedge clk_i) begin
    if (rx_window == 0) begin
      rx_window <= $urandom_range(300, 20);
      rx_calm   <= ($urandom_range(4, 0) == 0);
    end else begin
      rx_window <= rx_window - 1;
    end
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_calm || $urandom_range(3, 0) != 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      rx_hold       <= ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(2, 0);
    end
  end

  function automatic int unsigned tx_gap();
    int unsigned r;
    if (tx_calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // data with the extremes turning up often
  function automatic logic [HalfW-1:0] rand_half();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HalfW'($urandom_range(16'hffff, 0));
  endfunction

  // Present one request after an optional gap and hold it until taken.
  // tvalid is only lowered when a gap follows, so it never toggles in a step.
  task automatic send_req(input logic mode, input logic [IdxW-1:0] idx,
                          input logic [HalfW-1:0] data);
    int unsigned gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-IdxW-HalfW){1'b0}}, data, idx};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    req_sent++;
  endtask

  // tick requests carry junk in the ignored fields
  task automatic send_tick();
    send_req(ModeTick, IdxW'($urandom_range(7, 0)), rand_half());
  endtask

  // hold off until every predicted command has come out
  task automatic drain_cmds();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (cmds_pending != 0) @(posedge clk_i);
  endtask

  // Random request of any kind. Outside a run a control write keeps its
  // start bits clear, so a junk count can never launch a huge run.
  task automatic send_noise(input bit allow_start);
    logic [IdxW-1:0]  idx;
    logic [HalfW-1:0] data;
    idx  = IdxW'($urandom_range(7, 0));
    data = rand_half();
    if ($urandom_range(2, 0) == 0) begin
      send_tick();
    end else begin
      if (!allow_start && idx == RegCtrl) data = data & ~CtrlStartMask;
      send_req(ModeWrite, idx, data);
    end
  endtask

  // One programmed run: addresses (some halves kept from before), count,
  // control, then enough ticks to finish it with writes thrown in mid-run.
  task automatic run_transfer();
    logic [HalfW-1:0] ctrl;
    int unsigned      cnt;
    int unsigned      r;
    int unsigned      ticks;
    if ($urandom_range(4, 0) != 0) send_req(ModeWrite, RegSrcHi, rand_half());
    if ($urandom_range(4, 0) != 0) send_req(ModeWrite, RegSrcLo, rand_half());
    if ($urandom_range(4, 0) != 0) send_req(ModeWrite, RegDstHi, rand_half());
    if ($urandom_range(4, 0) != 0) send_req(ModeWrite, RegDstLo, rand_half());
    if ($urandom_range(5, 0) == 0) send_req(ModeWrite, RegCount, rand_half());
    r = $urandom_range(99, 0);
    if (r < 70)      cnt = $urandom_range(7, 0);
    else if (r < 95) cnt = $urandom_range(40, 8);
    else             cnt = $urandom_range(100, 41);
    send_req(ModeWrite, RegCount, HalfW'(cnt));
    if ($urandom_range(3, 0) == 0) send_noise(1'b0);
    ctrl = rand_half() & ~CtrlStartMask;
    case ($urandom_range(9, 0))
      0:       ;                                   // no start bit: ignored
      1, 2, 3: ctrl = ctrl | 16'h8000;
      4, 5, 6: ctrl = ctrl | 16'h0800;
      default: ctrl = ctrl | CtrlStartMask;
    endcase
    send_req(ModeWrite, RegCtrl, ctrl);
    ticks = cnt + 1 + $urandom_range(2, 0);
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(9, 0) == 0) send_noise(1'b1);
      send_tick();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    send_req(ModeTick, RegSrcHi, '0);               // tick while idle
    send_req(ModeWrite, RegSrcHi, 16'hffff);        // source wraps mid-run
    send_req(ModeWrite, RegSrcLo, 16'hffff);
    send_req(ModeWrite, RegDstHi, 16'h0000);
    send_req(ModeWrite, RegDstLo, 16'hfffe);
    send_req(ModeWrite, RegCount, 16'h0002);
    send_req(ModeWrite, RegCtrl, ~CtrlStartMask);   // every bit but the starts
    send_tick();
    send_req(ModeWrite, RegCtrl, 16'h8000 | CtrlWordBit);
    send_req(ModeWrite, RegSrcHi, 16'h1234);        // ignored while busy
    send_req(ModeWrite, RegSpare6, 16'hffff);
    send_req(ModeTick, RegSpare7, 16'hffff);
    send_tick();
    send_req(ModeWrite, RegCtrl, CtrlStartMask);    // restart ignored while busy
    send_tick();                                    // last of the run
    send_tick();                                    // idle again
    send_req(ModeWrite, RegCount, 16'h0000);
    send_req(ModeWrite, RegSpare7, 16'h5555);
    send_req(ModeWrite, RegCtrl, 16'h0800);         // byte run from advanced addresses
    send_tick();
    send_req(ModeWrite, RegCount, 16'hffff);
    send_req(ModeWrite, RegCount, 16'h0001);
    send_req(ModeWrite, RegCtrl, 16'hffff);
    send_tick();
    send_tick();
    drain_cmds();

    // --- random part: mostly well-formed runs, some junk bursts ---
    while (req_sent < TotalReqs) begin
      tx_calm = ($urandom_range(7, 0) == 0);
      if ($urandom_range(9, 0) < 8) begin
        run_transfer();
      end else begin
        repeat ($urandom_range(6, 1)) send_noise(1'b0);
      end
      if ($urandom_range(19, 0) == 0) drain_cmds();
    end

    drain_cmds();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0 && cmds_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dcbw_pkg.sv
hw/rtl/dcbw_seq.sv
hw/rtl/dma_copy_engine_byte_word.sv
tb/sv/dcbw_cmd_checker.sv
tb/sv/tb_top.sv
